// ----- rtl/core/itoar_pkg.sv -----
// Package for the integer-to-ASCII radix converter.
// Holds field widths, radix and character codes, and the control/status structs.
// No dependencies.
package itoar_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int VALUE_BITS      = 32;
    localparam int RADIX_BITS      = 5;
    localparam int CHAR_BITS       = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_BIN = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC = 5'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX = 5'd16;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h37;

    typedef struct packed {
        logic load;
        logic dab_step;
        logic skip;
        logic push_minus;
        logic push_digit;
        logic push_err;
    } itoar_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic in_dec;
        logic minus;
        logic cnt_last;
        logic top_zero;
        logic slot_free;
    } itoar_status_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
        begin
            return CHAR_ZERO + {3'b000, d};
        end
        return CHAR_ALPHA + {3'b000, d};
    endfunction

endpackage

// ----- rtl/core/itoar_in_if.sv -----
// Input channel: one number with its radix and signed flag per transfer.
// Depends on itoar_pkg.
interface itoar_in_if;
    import itoar_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
    logic                  signed_mode;

    modport source (output valid, value, radix, signed_mode, input ready);
    modport sink   (input valid, value, radix, signed_mode, output ready);
endinterface

// ----- rtl/core/itoar_out_if.sv -----
// Output channel: one ASCII character per transfer.
// Depends on itoar_pkg.
interface itoar_out_if;
    import itoar_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] ascii_char;
    logic                 last_char;
    logic                 bad_radix;

    modport source (output valid, ascii_char, last_char, bad_radix, input ready);
    modport sink   (input valid, ascii_char, last_char, bad_radix, output ready);
endinterface

// ----- rtl/core/integer_to_ascii_radix_top.sv -----
// Top level of the integer-to-ASCII radix converter: controller plus datapath.
// Depends on itoar_pkg, itoar_in_if, itoar_out_if, itoar_ctrl, itoar_dp.
//
//   port      dir   payload                          per transfer
//   in_item   sink  value[31:0] radix[4:0] signed    one number
//   out_char  src   ascii_char[6:0] last bad_radix   one character, MS first
//
// One number at a time: in_item.ready is high only between numbers.
// Power-of-two bases load, then skip leading zeros and emit the rest of the N digit
// positions (N = 32 for base 2); decimal runs VALUE_WIDTH shift-add-3 steps first.
// A sign character is emitted before the digits. Output stalls hold the sequencer.
// Reset clears the controller and output valid; no clearing pass is needed.
module integer_to_ascii_radix_top #(
    parameter int VALUE_WIDTH = itoar_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    itoar_in_if.sink    in_item,
    itoar_out_if.source out_char
);
    import itoar_pkg::*;

    itoar_cmd_t    cmd;
    itoar_status_t status;
    logic          in_ready;

    itoar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itoar_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (in_item.value),
        .radix       (in_item.radix),
        .signed_mode (in_item.signed_mode),
        .out_valid   (out_char.valid),
        .out_ready   (out_char.ready),
        .ascii_char  (out_char.ascii_char),
        .last_char   (out_char.last_char),
        .bad_radix   (out_char.bad_radix)
    );

    assign in_item.ready = in_ready;

endmodule

// ----- rtl/core/itoar_ctrl.sv -----
// Controller for the integer-to-ASCII converter: sequences load, decimal
// conversion, leading-zero skip and character output. Depends on itoar_pkg.
module itoar_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  itoar_pkg::itoar_status_t status,
    output itoar_pkg::itoar_cmd_t    cmd
);
    import itoar_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_SKIP = 6'b000100,
        S_SIGN = 6'b001000,
        S_EMIT = 6'b010000,
        S_ERR  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.in_bad)
                    begin
                        state_next = S_ERR;
                    end
                    else if (status.in_dec)
                    begin
                        state_next = S_CONV;
                    end
                    else
                    begin
                        state_next = S_SKIP;
                    end
                end
            end
            S_CONV:
            begin
                cmd.dab_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (status.top_zero && !status.cnt_last)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.minus)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (status.slot_free)
                begin
                    cmd.push_minus = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.push_digit = 1'b1;
                    if (status.cnt_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (status.slot_free)
                begin
                    cmd.push_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/itoar_dp.sv -----
// Datapath for the integer-to-ASCII converter: digit shift register, shift-add-3
// binary-to-BCD step, digit counter and output register. Depends on itoar_pkg.
module itoar_dp #(
    parameter int VALUE_WIDTH = itoar_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  itoar_pkg::itoar_cmd_t                cmd,
    output itoar_pkg::itoar_status_t             status,
    input  logic [itoar_pkg::VALUE_BITS-1:0]     value,
    input  logic [itoar_pkg::RADIX_BITS-1:0]     radix,
    input  logic                                 signed_mode,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [itoar_pkg::CHAR_BITS-1:0]      ascii_char,
    output logic                                 last_char,
    output logic                                 bad_radix
);
    import itoar_pkg::*;

    localparam int DEC_N  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int OCT_N  = (VALUE_WIDTH + 2) / 3;
    localparam int HEX_N  = (VALUE_WIDTH + 3) / 4;
    localparam int WORK_W = 4 * DEC_N;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int COPY_W = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
    localparam int SH_BIN = WORK_W - VALUE_WIDTH;
    localparam int SH_OCT = WORK_W - 3 * OCT_N;
    localparam int SH_HEX = WORK_W - 4 * HEX_N;

    typedef enum logic [1:0] {
        KIND_BIN,
        KIND_OCT,
        KIND_DEC,
        KIND_HEX
    } kind_t;

    function automatic logic [3:0] dab_adj(input logic [3:0] n);
        if (n >= 4'd5)
        begin
            return n + 4'd3;
        end
        return n;
    endfunction

    kind_t                kind_reg,      kind_next;
    logic                 minus_reg,     minus_next;
    logic [VALUE_WIDTH-1:0] bin_reg,     bin_next;
    logic [WORK_W-1:0]    work_reg,      work_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0] out_char_reg,  out_char_next;
    logic                 out_last_reg,  out_last_next;
    logic                 out_bad_reg,   out_bad_next;

    kind_t                in_kind;
    logic                 in_bad;
    logic                 in_neg;
    logic [VALUE_WIDTH-1:0] v_in;
    logic [VALUE_WIDTH-1:0] v_abs;
    logic [WORK_W-1:0]    wide_in;
    logic [WORK_W-1:0]    bcd_adj;
    logic [WORK_W-1:0]    work_shift;
    logic [3:0]           top_digit;
    logic                 cnt_last;
    logic                 slot_free;

    always_comb
    begin
        v_in = '0;
        for (int i = 0; i < COPY_W; i++)
        begin
            v_in[i] = value[i];
        end
    end

    assign in_neg  = signed_mode & v_in[VALUE_WIDTH-1];
    assign v_abs   = in_neg ? (~v_in + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v_in;
    assign wide_in = {{(WORK_W-VALUE_WIDTH){1'b0}}, v_abs};

    always_comb
    begin
        in_bad  = 1'b0;
        in_kind = KIND_DEC;
        if (!signed_mode)
        begin
            case (radix)
                RADIX_BIN: in_kind = KIND_BIN;
                RADIX_OCT: in_kind = KIND_OCT;
                RADIX_DEC: in_kind = KIND_DEC;
                RADIX_HEX: in_kind = KIND_HEX;
                default:
                begin
                    in_kind = KIND_HEX;
                    in_bad  = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int d = 0; d < DEC_N; d++)
        begin
            bcd_adj[4*d +: 4] = dab_adj(work_reg[4*d +: 4]);
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_BIN:
            begin
                top_digit  = {3'b000, work_reg[WORK_W-1]};
                work_shift = work_reg << 1;
            end
            KIND_OCT:
            begin
                top_digit  = {1'b0, work_reg[WORK_W-1 -: 3]};
                work_shift = work_reg << 3;
            end
            default:
            begin
                top_digit  = work_reg[WORK_W-1 -: 4];
                work_shift = work_reg << 4;
            end
        endcase
    end

    assign cnt_last  = (cnt_reg == CNT_W'(1));
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.in_bad    = in_bad;
        status.in_dec    = (in_kind == KIND_DEC);
        status.minus     = minus_reg;
        status.cnt_last  = cnt_last;
        status.top_zero  = (top_digit == 4'd0);
        status.slot_free = slot_free;
    end

    always_comb
    begin
        kind_next      = kind_reg;
        minus_next     = minus_reg;
        bin_next       = bin_reg;
        work_next      = work_reg;
        cnt_next       = cnt_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            kind_next  = in_kind;
            minus_next = in_neg;
            bin_next   = v_abs;
            case (in_kind)
                KIND_BIN:
                begin
                    work_next = wide_in << SH_BIN;
                    cnt_next  = CNT_W'(VALUE_WIDTH);
                end
                KIND_OCT:
                begin
                    work_next = wide_in << SH_OCT;
                    cnt_next  = CNT_W'(OCT_N);
                end
                KIND_HEX:
                begin
                    work_next = wide_in << SH_HEX;
                    cnt_next  = CNT_W'(HEX_N);
                end
                default:
                begin
                    work_next = '0;
                    cnt_next  = CNT_W'(VALUE_WIDTH);
                end
            endcase
        end

        if (cmd.dab_step)
        begin
            work_next = {bcd_adj[WORK_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next  = bin_reg << 1;
            cnt_next  = cnt_last ? CNT_W'(DEC_N) : cnt_reg - CNT_W'(1);
        end

        if (cmd.skip || cmd.push_digit)
        begin
            work_next = work_shift;
            cnt_next  = cnt_reg - CNT_W'(1);
        end

        if (cmd.push_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = digit_char(top_digit);
            out_last_next  = cnt_last;
            out_bad_next   = 1'b0;
        end

        if (cmd.push_minus)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CHAR_MINUS;
            out_last_next  = 1'b0;
            out_bad_next   = 1'b0;
            minus_next     = 1'b0;
        end

        if (cmd.push_err)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CHAR_NONE;
            out_last_next  = 1'b1;
            out_bad_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_DEC;
            minus_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            minus_reg     <= minus_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        work_reg     <= work_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = out_char_reg;
    assign last_char  = out_last_reg;
    assign bad_radix  = out_bad_reg;

endmodule
